/* sv/sdcp_pkg.sv */
`timescale 1ns / 1ps
// Package of the serial display command parser: word types and character codes.
// Used by the stream interface users, the top level and the checker.
package sdcp_pkg;

	localparam int CNT_W      = 4;
	localparam int KEPT_CHARS = 4;
	localparam int KEPT_IDX_W = 2;
	localparam int NUM_DIGITS = 6;
	localparam int DIG_IDX_W  = 3;

	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_SIX  = 8'h36;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [7:0] OP_DIGIT       = 8'h30;
	localparam logic [7:0] OP_POSS_OFF    = 8'h41;
	localparam logic [7:0] OP_POSS_LOCAL  = 8'h42;
	localparam logic [7:0] OP_POSS_VISIT  = 8'h43;
	localparam logic [7:0] OP_HUN_LOC_ON  = 8'h44;
	localparam logic [7:0] OP_HUN_LOC_OFF = 8'h45;
	localparam logic [7:0] OP_HUN_VIS_ON  = 8'h46;
	localparam logic [7:0] OP_HUN_VIS_OFF = 8'h47;
	localparam logic [7:0] OP_RESET       = 8'h5A;

	localparam int IND_POS_LOCAL   = 0;
	localparam int IND_POS_VISITOR = 1;
	localparam int IND_HUN_LOCAL   = 2;
	localparam int IND_HUN_VISITOR = 3;

	typedef struct packed {
		logic [7:0] rx_char;
	} in_word_t;

	typedef struct packed {
		logic [3:0] local_units;
		logic [3:0] local_tens;
		logic [3:0] visitor_tens;
		logic [3:0] visitor_units;
		logic [3:0] local_fouls;
		logic [3:0] visitor_fouls;
		logic       possession_local;
		logic       possession_visitor;
		logic       hundreds_local;
		logic       hundreds_visitor;
		logic       command_done;
		logic       reset_request;
	} out_word_t;

endpackage

/* sv/sdcp_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one word per handshake.
// The word type is a parameter; no other dependencies.
interface sdcp_stream_if #(parameter type T = logic [7:0]);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* sv/serial_display_command_parser.sv */
`timescale 1ns / 1ps
// Top level of the serial display command parser.
// Depends on sdcp_pkg and sdcp_stream_if.

// The parser takes one received character per clock cycle and returns one result word
// per character, in the cycle after the character is accepted. Each result shows the six
// BCD digit latches and four indicator lamps as they stand after that character, plus
// flags for a completed command and a reset request. The decode runs in a single
// combinational pass from the parser state to one output register, so the rate is one
// character per cycle; the input is stalled only while that output register holds a
// word that the sink has not taken.
module serial_display_command_parser import sdcp_pkg::*; #(
	parameter int MAX_CMD_CHARS = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	sdcp_stream_if.sink   in_ch,
	sdcp_stream_if.source out_ch
);

	logic                  collecting_q;
	logic [CNT_W-1:0]      char_count_q;
	logic [KEPT_CHARS-1:0][7:0] cmd_q;
	logic [NUM_DIGITS-1:0][3:0] digit_q;
	logic [3:0]            ind_q;

	logic                  collecting_d;
	logic [CNT_W-1:0]      char_count_d;
	logic [KEPT_CHARS-1:0][7:0] cmd_d;
	logic [NUM_DIGITS-1:0][3:0] digit_d;
	logic [3:0]            ind_d;

	logic       out_valid_q;
	out_word_t  out_q;
	out_word_t  result;
	logic       accept;
	logic       is_term;
	logic       done;
	logic       rst_req;
	logic [7:0] ch;
	logic [7:0] op;
	logic [7:0] port;
	logic [7:0] val;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign ch          = in_ch.data.rx_char;
	assign op          = cmd_q[0];
	assign port        = cmd_q[2];
	assign val         = cmd_q[3];
	assign is_term     = (ch == CH_HASH) || (ch == CH_CR);
	assign done        = collecting_q && is_term;

	always_comb begin
		collecting_d = collecting_q;
		char_count_d = char_count_q;
		cmd_d        = cmd_q;
		digit_d      = digit_q;
		ind_d        = ind_q;
		rst_req      = 1'b0;

		if (done) begin
			collecting_d = 1'b0;
			case (op)
				OP_DIGIT: begin
					if (port inside {[CH_ONE:CH_SIX]}) begin
						if (val inside {[CH_ZERO:CH_NINE]}) begin
							digit_d[DIG_IDX_W'(port - CH_ONE)] = 4'(val - CH_ZERO);
						end else begin
							digit_d[DIG_IDX_W'(port - CH_ONE)] = 4'd0;
						end
					end
				end
				OP_POSS_OFF: begin
					ind_d[IND_POS_LOCAL]   = 1'b0;
					ind_d[IND_POS_VISITOR] = 1'b0;
				end
				OP_POSS_LOCAL: begin
					ind_d[IND_POS_LOCAL]   = 1'b1;
					ind_d[IND_POS_VISITOR] = 1'b0;
				end
				OP_POSS_VISIT: begin
					ind_d[IND_POS_LOCAL]   = 1'b0;
					ind_d[IND_POS_VISITOR] = 1'b1;
				end
				OP_HUN_LOC_ON:  ind_d[IND_HUN_LOCAL] = 1'b1;
				OP_HUN_LOC_OFF: ind_d[IND_HUN_LOCAL] = 1'b0;
				OP_HUN_VIS_ON:  ind_d[IND_HUN_VISITOR] = 1'b1;
				OP_HUN_VIS_OFF: ind_d[IND_HUN_VISITOR] = 1'b0;
				OP_RESET:       rst_req = 1'b1;
				default: begin
				end
			endcase
		end else if (collecting_q && (char_count_q < CNT_W'(MAX_CMD_CHARS))) begin
			if (char_count_q < CNT_W'(KEPT_CHARS)) begin
				cmd_d[char_count_q[KEPT_IDX_W-1:0]] = ch;
			end
			char_count_d = char_count_q + CNT_W'(1);
		end

		if (ch == CH_DASH) begin
			collecting_d = 1'b1;
			char_count_d = '0;
			cmd_d        = '0;
		end

		if (rst_req) begin
			collecting_d = 1'b0;
			char_count_d = '0;
			cmd_d        = '0;
			digit_d      = '0;
			ind_d        = '0;
		end
	end

	always_comb begin
		result.local_units        = digit_d[0];
		result.local_tens         = digit_d[1];
		result.visitor_tens       = digit_d[2];
		result.visitor_units      = digit_d[3];
		result.local_fouls        = digit_d[4];
		result.visitor_fouls      = digit_d[5];
		result.possession_local   = ind_d[IND_POS_LOCAL];
		result.possession_visitor = ind_d[IND_POS_VISITOR];
		result.hundreds_local     = ind_d[IND_HUN_LOCAL];
		result.hundreds_visitor   = ind_d[IND_HUN_VISITOR];
		result.command_done       = done;
		result.reset_request      = rst_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			char_count_q <= '0;
			cmd_q        <= '0;
			digit_q      <= '0;
			ind_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				collecting_q <= collecting_d;
				char_count_q <= char_count_d;
				cmd_q        <= cmd_d;
				digit_q      <= digit_d;
				ind_q        <= ind_d;
				out_valid_q  <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

endmodule

/* sv/sdcp_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the serial display command parser, with its bind statement.
// Depends on sdcp_pkg and the top level serial_display_command_parser.
module sdcp_protocol_checker import sdcp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	// A stalled result word must hold until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// Every accepted character yields a result word in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted character gave no result word");

	// No character is taken while a result word waits on a stalled sink.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("character accepted over a stalled result");

	// A reset request ends a command and shows a cleared display.
	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reset_request |-> out_data.command_done
			&& out_data.local_units == 4'd0 && out_data.local_tens == 4'd0
			&& out_data.visitor_tens == 4'd0 && out_data.visitor_units == 4'd0
			&& out_data.local_fouls == 4'd0 && out_data.visitor_fouls == 4'd0
			&& !out_data.possession_local && !out_data.possession_visitor
			&& !out_data.hundreds_local && !out_data.hundreds_visitor)
		else $error("reset request without a cleared display");

endmodule

bind serial_display_command_parser sdcp_protocol_checker u_sdcp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

/* bench/sdcp_checker.sv */
`timescale 1ns / 1ps
// Checker for the serial display command parser: watches both channels, predicts each
// result word from the accepted characters and compares it field by field.
// Depends on sdcp_pkg.
module sdcp_checker import sdcp_pkg::*; #(
	parameter int MAX_CMD_CHARS = 9
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_data,
	output int        fail_count,
	output int        pending
);

	logic             collecting;
	logic [CNT_W-1:0] char_count;
	logic [7:0]       cmd_chars [KEPT_CHARS];
	logic [3:0]       digits [NUM_DIGITS];
	logic [3:0]       lamps;
	out_word_t        expected_words [$];
	out_word_t        oldest_word;

	function automatic void clear_display();
		collecting = 1'b0;
		char_count = '0;
		foreach (cmd_chars[i]) cmd_chars[i] = 8'h00;
		foreach (digits[i]) digits[i] = 4'h0;
		lamps = 4'h0;
	endfunction

	function automatic out_word_t predict_display_word(input logic [7:0] ch);
		out_word_t  w;
		logic       done;
		logic       rst;
		logic [7:0] port;
		logic [7:0] val;
		logic [7:0] val_off;
		logic [7:0] port_off;
		done = 1'b0;
		rst  = 1'b0;
		if (collecting) begin
			if (ch == CH_HASH || ch == CH_CR) begin
				collecting = 1'b0;
				done = 1'b1;
				port = cmd_chars[2];
				val  = cmd_chars[3];
				case (cmd_chars[0])
					OP_DIGIT: begin
						if (port >= CH_ONE && port <= CH_SIX) begin
							port_off = port - CH_ONE;
							val_off  = val - CH_ZERO;
							if (val >= CH_ZERO && val <= CH_NINE)
								digits[port_off] = val_off[3:0];
							else
								digits[port_off] = 4'h0;
						end
					end
					OP_POSS_OFF: begin
						lamps[IND_POS_LOCAL]   = 1'b0;
						lamps[IND_POS_VISITOR] = 1'b0;
					end
					OP_POSS_LOCAL: begin
						lamps[IND_POS_LOCAL]   = 1'b1;
						lamps[IND_POS_VISITOR] = 1'b0;
					end
					OP_POSS_VISIT: begin
						lamps[IND_POS_LOCAL]   = 1'b0;
						lamps[IND_POS_VISITOR] = 1'b1;
					end
					OP_HUN_LOC_ON:  lamps[IND_HUN_LOCAL] = 1'b1;
					OP_HUN_LOC_OFF: lamps[IND_HUN_LOCAL] = 1'b0;
					OP_HUN_VIS_ON:  lamps[IND_HUN_VISITOR] = 1'b1;
					OP_HUN_VIS_OFF: lamps[IND_HUN_VISITOR] = 1'b0;
					OP_RESET:       rst = 1'b1;
					default: ;
				endcase
			end else if (char_count < MAX_CMD_CHARS) begin
				if (char_count < KEPT_CHARS)
					cmd_chars[char_count[KEPT_IDX_W-1:0]] = ch;
				char_count = char_count + 1'b1;
			end
		end
		if (ch == CH_DASH) begin
			collecting = 1'b1;
			char_count = '0;
			foreach (cmd_chars[i]) cmd_chars[i] = 8'h00;
		end
		if (rst)
			clear_display();
		w.local_units        = digits[0];
		w.local_tens         = digits[1];
		w.visitor_tens       = digits[2];
		w.visitor_units      = digits[3];
		w.local_fouls        = digits[4];
		w.visitor_fouls      = digits[5];
		w.possession_local   = lamps[IND_POS_LOCAL];
		w.possession_visitor = lamps[IND_POS_VISITOR];
		w.hundreds_local     = lamps[IND_HUN_LOCAL];
		w.hundreds_visitor   = lamps[IND_HUN_VISITOR];
		w.command_done       = done;
		w.reset_request      = rst;
		return w;
	endfunction

	task automatic check_field(input string field, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch on %s: expected %0d, got %0d", field, exp_v, act_v);
		end
	endtask

	task automatic check_word(input out_word_t e, input out_word_t a);
		check_field("local_units", e.local_units, a.local_units);
		check_field("local_tens", e.local_tens, a.local_tens);
		check_field("visitor_tens", e.visitor_tens, a.visitor_tens);
		check_field("visitor_units", e.visitor_units, a.visitor_units);
		check_field("local_fouls", e.local_fouls, a.local_fouls);
		check_field("visitor_fouls", e.visitor_fouls, a.visitor_fouls);
		check_field("possession_local", e.possession_local, a.possession_local);
		check_field("possession_visitor", e.possession_visitor, a.possession_visitor);
		check_field("hundreds_local", e.hundreds_local, a.hundreds_local);
		check_field("hundreds_visitor", e.hundreds_visitor, a.hundreds_visitor);
		check_field("command_done", e.command_done, a.command_done);
		check_field("reset_request", e.reset_request, a.reset_request);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_display();
			expected_words.delete();
			pending = 0;
		end else begin
			if (in_valid && in_ready)
				expected_words.push_back(predict_display_word(in_data.rx_char));
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word %h", out_data);
				end else begin
					oldest_word = expected_words.pop_front();
					check_word(oldest_word, out_data);
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Top of the bench: clock, reset, character stimulus and the verdict.
// Depends on sdcp_pkg, sdcp_stream_if, the parser top level and sdcp_checker.
module testbench;
	import sdcp_pkg::*;

	localparam int         MAX_CHARS   = 9;
	localparam int         TOTAL_ITEMS = 1650;
	localparam int         CYCLE_LIMIT = 400000;
	localparam logic [7:0] CH_TEST     = 8'h58;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   items_sent;
	int   cycle_count;
	int   fail_count;
	int   pending;

	sdcp_stream_if #(.T(in_word_t))  in_ch ();
	sdcp_stream_if #(.T(out_word_t)) out_ch ();

	serial_display_command_parser #(.MAX_CMD_CHARS(MAX_CHARS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	sdcp_checker #(.MAX_CMD_CHARS(MAX_CHARS)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 17;
		recv_idle_pct = 74;
		items_sent = 0;
		cycle_count = 0;
	end

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data.rx_char <= ch;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send_random_command();
		logic [7:0] body [$];
		logic [7:0] op;
		int         pick;
		int         cut;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(4, 1))
				send_char(8'($urandom));
			return;
		end
		send_char(CH_DASH);
		pick = $urandom_range(99);
		if (pick < 45)
			op = OP_DIGIT;
		else if (pick < 80)
			op = OP_POSS_OFF + 8'($urandom_range(6));
		else if (pick < 83)
			op = OP_RESET;
		else if (pick < 88)
			op = CH_TEST;
		else
			op = 8'($urandom);
		body.push_back(op);
		if (op == OP_DIGIT) begin
			body.push_back(8'($urandom));
			if ($urandom_range(99) < 85)
				body.push_back(CH_ONE + 8'($urandom_range(5)));
			else
				body.push_back(8'($urandom));
			if ($urandom_range(99) < 85)
				body.push_back(CH_ZERO + 8'($urandom_range(9)));
			else
				body.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(2))
				body.push_back(8'($urandom));
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			cut = $urandom_range(body.size());
			while (body.size() > cut)
				void'(body.pop_back());
		end else if (pick < 20) begin
			while (body.size() < $urandom_range(14, 8))
				body.push_back(8'($urandom));
		end
		foreach (body[i])
			send_char(body[i]);
		pick = $urandom_range(99);
		if (pick < 48)
			send_char(CH_HASH);
		else if (pick < 95)
			send_char(CH_CR);
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_char(CH_HASH);
		send_char(CH_CR);
		send_char(CH_DASH);
		send_char(OP_DIGIT);
		send_char(8'hFF);
		send_char(CH_SIX);
		send_char(CH_NINE);
		send_char(CH_HASH);
		send_char(CH_DASH);
		send_char(OP_POSS_LOCAL);
		send_char(CH_CR);
		send_char(CH_DASH);
		send_char(OP_HUN_LOC_ON);
		send_char(CH_DASH);
		send_char(OP_HUN_VIS_ON);
		send_char(CH_HASH);
		send_char(CH_DASH);
		send_char(OP_DIGIT);
		send_char(8'h00);
		send_char(CH_SIX + 8'd1);
		send_char(CH_HASH);
		send_char(CH_DASH);
		send_char(OP_RESET);
		send_char(CH_HASH);

		while (items_sent < TOTAL_ITEMS / 3)
			send_random_command();
		wait_drained();
		send_idle_pct = 74;
		recv_idle_pct = 17;
		while (items_sent < 2 * TOTAL_ITEMS / 3)
			send_random_command();
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (items_sent < TOTAL_ITEMS)
			send_random_command();
		wait_drained();
		repeat (10) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
